>>> rtl/wall_clock_civil_date_top_defines.svh
// assertion macros used by the wall clock checker
`ifndef WALL_CLOCK_CIVIL_DATE_TOP_DEFINES_SVH
`define WALL_CLOCK_CIVIL_DATE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define WCD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define WCD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wcd_pkg.sv
// types and constants of the wall clock with civil date readout
package wcd_pkg;

  // command codes on the action field
  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2
  } act_t;

  // microsecond ticks per second and the width of the tick counter
  localparam int unsigned USEC_W           = 20;
  localparam int unsigned TICKS_PER_SECOND = 1000000;

  // calendar constants
  localparam logic [19:0] EPOCH_SHIFT = 20'd719468;  // days from 0000-03-01 to 1970-01-01
  localparam logic [19:0] ERA_DAYS    = 20'd146097;  // days in 400 years
  localparam logic [17:0] CENT_DAYS   = 18'd36524;   // days in 100 years
  localparam logic [17:0] ERA_LAST    = 18'd146096;
  localparam logic [16:0] DAY_SECS    = 17'd86400;
  localparam logic [16:0] HOUR_SECS   = 17'd3600;

  // reciprocals for exact division by constants: q = (x * M) >> S
  localparam logic [25:0] M_DAY  = 26'd50903317;  // x / 675,  x < 2^25, S = 35
  localparam logic [17:0] M_HR   = 18'd149131;    // x / 3600, x < 2^17, S = 29
  localparam logic [18:0] M_1460 = 19'd367720;    // x / 1460, x < 2^18, S = 29
  localparam logic [18:0] M_365  = 19'd367720;    // x / 365,  x < 2^18, S = 27
  localparam logic [12:0] M_60   = 13'd4370;      // x / 60,   x < 2^12, S = 18
  localparam logic [11:0] M_153  = 12'd3427;      // x / 153,  x < 2^11, S = 19
  localparam logic [11:0] M_5    = 12'd3277;      // x / 5,    x < 2^11, S = 14

  // read pipeline depth ahead of the result register
  localparam int unsigned NS = 12;

  // one read in flight through the date pipeline
  typedef struct packed {
    logic               set;
    logic [31:0]        utc;
    logic signed [11:0] off;
    logic [31:0]        local_s;
    logic [15:0]        days;
    logic [16:0]        sod;
    logic [19:0]        z;
    logic [2:0]         era;
    logic [17:0]        doe;
    logic [4:0]         hour;
    logic [6:0]         q1460;
    logic [2:0]         qc;
    logic               qb;
    logic [11:0]        ms;
    logic [17:0]        t;
    logic [5:0]         minute;
    logic [8:0]         yoe;
    logic [5:0]         second;
    logic [8:0]         doy;
    logic [3:0]         mp;
    logic [10:0]        a;
    logic [3:0]         mo;
    logic [4:0]         dy;
    logic [11:0]        yr;
  } rd_t;

endpackage

>>> rtl/wcd_if.sv
// command and response channels of the wall clock

// command channel: set, tick or read
interface wcd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] new_utc_seconds;

  modport source (output valid, action, new_utc_seconds, input ready);
  modport sink (input valid, action, new_utc_seconds, output ready);
endinterface

// response channel: one item per read
interface wcd_rsp_if;
  logic        valid;
  logic        ready;
  logic        time_valid;
  logic [31:0] utc_now;
  logic [11:0] local_year;
  logic [3:0]  local_month;
  logic [4:0]  local_day;
  logic [4:0]  local_hour;
  logic [5:0]  local_minute;
  logic [5:0]  local_second;

  modport source (output valid, time_valid, utc_now, local_year, local_month, local_day,
                  local_hour, local_minute, local_second, input ready);
  modport sink (input valid, time_valid, utc_now, local_year, local_month, local_day,
                local_hour, local_minute, local_second, output ready);
endinterface

>>> rtl/wall_clock_civil_date_top.sv
// wall clock top level: counters, offset register and civil date pipeline
//
// Usage:
//   cmd carries one command per transfer: set loads the UTC second and marks the
//   clock as set, tick counts one microsecond, read asks for the time. Action
//   code 3 is taken and ignored.
//   rsp carries one item for each read: set flag, UTC seconds and the local
//   civil date and time (UTC plus offset, in minutes east). An unset clock
//   reads as all zeros.
//   cfg_we/cfg_wdata write the signed offset in minutes; it takes effect on
//   reads that are taken after the write.
// Throughput: one command per cycle, reads included, while cmd.ready is high.
// Pipeline: a read transfer reaches rsp through 13 register stages, the last
//   being the response register; sets and ticks act on the next read at once.
// Reset: clears the counters, the set flag, the offset and all pipeline
//   valids; the first command is taken in the cycle after rst falls.
// Stalls: when rsp is held off, the result stays in the response register and
//   the pipeline closes up its empty stages; cmd.ready drops only once every
//   stage holds a read.
module wall_clock_civil_date_top
  import wcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [11:0]  cfg_wdata,
  wcd_cmd_if.sink      cmd,
  wcd_rsp_if.source    rsp
);

  // clock state
  logic [31:0]       seconds_count;
  logic [USEC_W-1:0] microsecond_count;
  logic [USEC_W-1:0] usec_inc;
  logic              is_set;
  logic signed [11:0] offset_minutes;

  // read pipeline
  rd_t            stg      [NS];
  rd_t            stg_next [NS];
  logic [NS-1:0]  vld;
  logic [NS-1:0]  en;
  logic           en_out;
  logic           cmd_fire;

  // response register
  logic        rsp_vld;
  logic        rsp_set;
  logic [31:0] rsp_utc;
  logic [11:0] rsp_yr;
  logic [3:0]  rsp_mo;
  logic [4:0]  rsp_dy;
  logic [4:0]  rsp_hr;
  logic [5:0]  rsp_min;
  logic [5:0]  rsp_sec;

  // arithmetic inside the stages
  logic signed [17:0] off_sec;
  logic [50:0] day_prod;
  logic [34:0] hr_prod;
  logic [36:0] q1460_prod;
  logic [24:0] min_prod;
  logic [36:0] yoe_prod;
  logic [10:0] mp_arg;
  logic [22:0] mp_prod;
  logic [22:0] a_prod;
  logic [1:0]  c100;

  // stage enables: a stage loads when the response register, the stage itself or
  // some later stage has room
  assign en_out = !rsp_vld || rsp.ready;
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = en_out || (((~vld) >> k) != '0);
    end
  end

  assign cmd.ready = en[0];
  assign cmd_fire  = cmd.valid && cmd.ready;

  // offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_minutes <= '0;
    end else if (cfg_we) begin
      offset_minutes <= signed'(cfg_wdata);
    end
  end

  // seconds and microsecond counters, set flag
  assign usec_inc = microsecond_count + USEC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count     <= '0;
      microsecond_count <= '0;
      is_set            <= 1'b0;
    end else if (cmd_fire) begin
      case (cmd.action)
        ACT_SET: begin
          seconds_count     <= cmd.new_utc_seconds;
          microsecond_count <= '0;
          is_set            <= 1'b1;
        end
        ACT_TICK: begin
          if (usec_inc >= USEC_W'(TICKS_PER_SECOND)) begin
            microsecond_count <= '0;
            seconds_count     <= seconds_count + 32'd1;
          end else begin
            microsecond_count <= usec_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // stage logic
  always_comb begin
    // capture the clock as the read is taken
    stg_next[0]     = stg[0];
    stg_next[0].set = is_set;
    stg_next[0].utc = seconds_count;
    stg_next[0].off = offset_minutes;

    // local seconds, wrapping to 32 bits
    off_sec                 = stg[0].off * 18'sd60;
    stg_next[1]             = stg[0];
    stg_next[1].local_s     = stg[0].utc + unsigned'(32'(off_sec));

    // days since epoch: (local >> 7) / 675
    day_prod                = 51'(stg[1].local_s[31:7]) * 51'(M_DAY);
    stg_next[2]             = stg[1];
    stg_next[2].days        = day_prod[50:35];

    // seconds of day and shifted day count
    stg_next[3]             = stg[2];
    stg_next[3].sod         = 17'(stg[2].local_s - 32'(stg[2].days) * 32'(DAY_SECS));
    stg_next[3].z           = 20'(stg[2].days) + EPOCH_SHIFT;

    // era and day of era, hour
    stg_next[4]             = stg[3];
    stg_next[4].era         = 3'(stg[3].z >= ERA_DAYS) + 3'(stg[3].z >= 20'(2 * ERA_DAYS))
                            + 3'(stg[3].z >= 20'(3 * ERA_DAYS))
                            + 3'(stg[3].z >= 20'(4 * ERA_DAYS))
                            + 3'(stg[3].z >= 20'(5 * ERA_DAYS));
    stg_next[4].doe         = 18'(stg[3].z - 20'(stg_next[4].era) * ERA_DAYS);
    hr_prod                 = 35'(stg[3].sod) * 35'(M_HR);
    stg_next[4].hour        = hr_prod[33:29];

    // leap corrections of the year-of-era formula, seconds within the hour
    q1460_prod              = 37'(stg[4].doe) * 37'(M_1460);
    stg_next[5]             = stg[4];
    stg_next[5].q1460       = q1460_prod[35:29];
    stg_next[5].qc          = 3'(stg[4].doe >= CENT_DAYS) + 3'(stg[4].doe >= 18'(2 * CENT_DAYS))
                            + 3'(stg[4].doe >= 18'(3 * CENT_DAYS))
                            + 3'(stg[4].doe >= ERA_LAST);
    stg_next[5].qb          = stg[4].doe >= ERA_LAST;
    stg_next[5].ms          = 12'(stg[4].sod - 17'(stg[4].hour) * HOUR_SECS);

    // corrected day of era, minute
    stg_next[6]             = stg[5];
    stg_next[6].t           = stg[5].doe - 18'(stg[5].q1460) + 18'(stg[5].qc)
                            - 18'(stg[5].qb);
    min_prod                = 25'(stg[5].ms) * 25'(M_60);
    stg_next[6].minute      = min_prod[23:18];

    // year of era, second
    yoe_prod                = 37'(stg[6].t) * 37'(M_365);
    stg_next[7]             = stg[6];
    stg_next[7].yoe         = yoe_prod[35:27];
    stg_next[7].second      = 6'(stg[6].ms - 12'(stg[6].minute) * 12'd60);

    // day of year, March based
    c100                    = 2'(stg[7].yoe >= 9'd100) + 2'(stg[7].yoe >= 9'd200)
                            + 2'(stg[7].yoe >= 9'd300);
    stg_next[8]             = stg[7];
    stg_next[8].doy         = 9'(stg[7].doe - (18'(stg[7].yoe) * 18'd365
                            + 18'(stg[7].yoe >> 2) - 18'(c100)));

    // month index from March
    mp_arg                  = 11'(stg[8].doy) * 11'd5 + 11'd2;
    mp_prod                 = 23'(mp_arg) * 23'(M_153);
    stg_next[9]             = stg[8];
    stg_next[9].mp          = mp_prod[22:19];

    // calendar month and first day offset of the month
    stg_next[10]            = stg[9];
    stg_next[10].a          = 11'(stg[9].mp) * 11'd153 + 11'd2;
    stg_next[10].mo         = (stg[9].mp < 4'd10) ? stg[9].mp + 4'd3 : stg[9].mp - 4'd9;

    // day of month and civil year
    a_prod                  = 23'(stg[10].a) * 23'(M_5);
    stg_next[11]            = stg[10];
    stg_next[11].dy         = 5'(stg[10].doy - a_prod[22:14] + 9'd1);
    stg_next[11].yr         = 12'(stg[10].yoe) + 12'(stg[10].era) * 12'd400
                            + 12'(stg[10].mo <= 4'd2);
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= cmd.valid && (cmd.action == ACT_READ);
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  // response register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (en_out) begin
      rsp_vld <= vld[NS-1];
    end
  end

  // response register payload, all zero while unset
  always_ff @(posedge clk) begin
    if (en_out) begin
      rsp_set <= stg[NS-1].set;
      rsp_utc <= stg[NS-1].set ? stg[NS-1].utc    : '0;
      rsp_yr  <= stg[NS-1].set ? stg[NS-1].yr     : '0;
      rsp_mo  <= stg[NS-1].set ? stg[NS-1].mo     : '0;
      rsp_dy  <= stg[NS-1].set ? stg[NS-1].dy     : '0;
      rsp_hr  <= stg[NS-1].set ? stg[NS-1].hour   : '0;
      rsp_min <= stg[NS-1].set ? stg[NS-1].minute : '0;
      rsp_sec <= stg[NS-1].set ? stg[NS-1].second : '0;
    end
  end

  // response channel
  assign rsp.valid        = rsp_vld;
  assign rsp.time_valid   = rsp_set;
  assign rsp.utc_now      = rsp_utc;
  assign rsp.local_year   = rsp_yr;
  assign rsp.local_month  = rsp_mo;
  assign rsp.local_day    = rsp_dy;
  assign rsp.local_hour   = rsp_hr;
  assign rsp.local_minute = rsp_min;
  assign rsp.local_second = rsp_sec;

endmodule

>>> rtl/wcd_chk.sv
// port-level checker for the wall clock, bound to the top level
`include "wall_clock_civil_date_top_defines.svh"

module wcd_chk (
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        time_valid,
  input logic [31:0] utc_now,
  input logic [11:0] local_year,
  input logic [3:0]  local_month,
  input logic [4:0]  local_day,
  input logic [4:0]  local_hour,
  input logic [5:0]  local_minute,
  input logic [5:0]  local_second
);

  logic        fields_zero;
  logic        date_ok;
  logic        rsp_stall;
  logic [70:0] rsp_word;

  // all readout fields at zero
  assign fields_zero = utc_now == 32'd0 && local_year == 12'd0 && local_month == 4'd0
                    && local_day == 5'd0 && local_hour == 5'd0 && local_minute == 6'd0
                    && local_second == 6'd0;

  // civil date and time fields in range
  assign date_ok = local_month >= 4'd1 && local_month <= 4'd12 && local_day >= 5'd1
                && local_day <= 5'd31 && local_hour <= 5'd23 && local_minute <= 6'd59
                && local_second <= 6'd59;

  // response held off by the receiver, and the whole readout
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_word  = {time_valid, utc_now, local_year, local_month, local_day, local_hour,
                      local_minute, local_second};

  // unset clock reads as all zeros
  `WCD_ASSERT_IMP(a_unset_zero, rsp_valid && !time_valid, fields_zero, "unset read not zero")

  // set clock gives a well-formed civil date and time
  `WCD_ASSERT_IMP(a_date_range, rsp_valid && time_valid, date_ok, "date field out of range")

  // with the response register empty the command side is open
  `WCD_ASSERT_IMP(a_ready_when_empty, !rsp_valid, cmd_ready, "ready low with empty response")

  // a stalled response holds
  `WCD_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "held response changed")

endmodule

bind wall_clock_civil_date_top wcd_chk u_wcd_chk (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .time_valid   (rsp.time_valid),
  .utc_now      (rsp.utc_now),
  .local_year   (rsp.local_year),
  .local_month  (rsp.local_month),
  .local_day    (rsp.local_day),
  .local_hour   (rsp.local_hour),
  .local_minute (rsp.local_minute),
  .local_second (rsp.local_second)
);
